FILE: design/abu_pkg.sv
// Shared types and helpers for the bit and byte manipulation pipeline.
// Holds the operation codes, the stage payload structs and the byte lead-zero helper.
// No dependencies; used by every module under design.
package abu_pkg;

  typedef enum logic [3:0] {
    ACT_CLZ   = 4'd0,
    ACT_BFI   = 4'd1,
    ACT_BFC   = 4'd2,
    ACT_SBFX  = 4'd3,
    ACT_UBFX  = 4'd4,
    ACT_REV   = 4'd5,
    ACT_REV16 = 4'd6,
    ACT_RBIT  = 4'd7,
    ACT_REVSH = 4'd8
  } action_t;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [4:0]  TOP_BIT  = 5'd31;

  // Payload leaving the first stage: masks, shifted words and per-byte zero counts.
  typedef struct packed {
    action_t          action;
    logic [31:0]      a;
    logic [31:0]      fm;
    logic [31:0]      b_sh;
    logic [31:0]      a_top;
    logic [4:0]       lsb;
    logic [4:0]       ext_w;
    logic             sign;
    logic [31:0]      perm;
    logic [3:0]       byte_zero;
    logic [3:0][2:0]  byte_lz;
  } prep_t;

  // Payload leaving the second stage: candidate results per operation group.
  typedef struct packed {
    action_t     action;
    logic [31:0] bf;
    logic [31:0] ext_f;
    logic [31:0] ext_m;
    logic        sext;
    logic [5:0]  clz;
    logic [31:0] perm;
  } comb_t;

  // Leading zeros of a nonzero byte.
  function automatic logic [2:0] byte_lz(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        n = 3'(7 - i);
      end
    end
    return n;
  endfunction

endpackage

FILE: design/abu_prep.sv
// First pipeline stage: field masks, operand shifts, word permutations and
// per-byte leading-zero counts. Depends on abu_pkg.
module abu_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       action,
  input  logic [31:0]      operand_a,
  input  logic [31:0]      operand_b,
  input  logic [4:0]       lsb,
  input  logic [4:0]       msb,
  input  logic [4:0]       width_minus_one,
  output logic             valid,
  output abu_pkg::prep_t   data,
  input  logic             ready_out
);

  abu_pkg::prep_t  data_next;
  abu_pkg::action_t act;
  logic [5:0]      ext_sum;
  logic [4:0]      ext_hi;
  logic [31:0]     rbit;

  assign act      = abu_pkg::action_t'(action);
  assign in_ready = !valid || ready_out;

  // Cut an extract field that runs past the top bit.
  assign ext_sum = {1'b0, lsb} + {1'b0, width_minus_one};
  assign ext_hi  = ext_sum[5] ? abu_pkg::TOP_BIT : ext_sum[4:0];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rbit[i] = operand_a[31 - i];
    end
  end

  always_comb begin
    data_next.action = act;
    data_next.a      = operand_a;
    // Bits lsb..msb; empty when msb is below lsb.
    data_next.fm     = (abu_pkg::ALL_ONES >> (abu_pkg::TOP_BIT - msb)) &
                       (abu_pkg::ALL_ONES << lsb);
    data_next.b_sh   = operand_b << lsb;
    data_next.a_top  = operand_a & (abu_pkg::ALL_ONES >> (abu_pkg::TOP_BIT - ext_hi));
    data_next.lsb    = lsb;
    data_next.ext_w  = ext_hi - lsb;
    data_next.sign   = operand_a[ext_hi];
    case (act)
      abu_pkg::ACT_REV:   data_next.perm = {operand_a[7:0], operand_a[15:8],
                                            operand_a[23:16], operand_a[31:24]};
      abu_pkg::ACT_REV16: data_next.perm = {operand_a[23:16], operand_a[31:24],
                                            operand_a[7:0], operand_a[15:8]};
      abu_pkg::ACT_RBIT:  data_next.perm = rbit;
      abu_pkg::ACT_REVSH: data_next.perm = {{16{operand_a[7]}}, operand_a[7:0],
                                            operand_a[15:8]};
      default:            data_next.perm = '0;
    endcase
    for (int k = 0; k < 4; k++) begin
      data_next.byte_zero[k] = (operand_a[8*k +: 8] == 8'd0);
      data_next.byte_lz[k]   = abu_pkg::byte_lz(operand_a[8*k +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

FILE: design/abu_comb.sv
// Second pipeline stage: bitfield merge, extract shift and mask, and the
// leading-zero count from the per-byte counts. Depends on abu_pkg.
module abu_comb (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  abu_pkg::prep_t  in_data,
  output logic            valid,
  output abu_pkg::comb_t  data,
  input  logic            ready_out
);

  abu_pkg::comb_t data_next;

  assign in_ready = !valid || ready_out;

  always_comb begin
    data_next.action = in_data.action;
    data_next.bf     = in_data.a & ~in_data.fm;
    if (in_data.action == abu_pkg::ACT_BFI) begin
      data_next.bf = (in_data.a & ~in_data.fm) | (in_data.b_sh & in_data.fm);
    end
    data_next.ext_f = in_data.a_top >> in_data.lsb;
    data_next.ext_m = abu_pkg::ALL_ONES >> (abu_pkg::TOP_BIT - in_data.ext_w);
    data_next.sext  = in_data.sign && (in_data.action == abu_pkg::ACT_SBFX);
    data_next.perm  = in_data.perm;
    // First nonzero byte from the top sets the count; all zero gives 32.
    if (!in_data.byte_zero[3]) begin
      data_next.clz = {3'd0, in_data.byte_lz[3]};
    end else if (!in_data.byte_zero[2]) begin
      data_next.clz = {3'd1, in_data.byte_lz[2]};
    end else if (!in_data.byte_zero[1]) begin
      data_next.clz = {3'd2, in_data.byte_lz[1]};
    end else if (!in_data.byte_zero[0]) begin
      data_next.clz = {3'd3, in_data.byte_lz[0]};
    end else begin
      data_next.clz = 6'd32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

FILE: design/abu_sel.sv
// Third pipeline stage: sign extension of extracts and the final result
// select into the output register. Depends on abu_pkg.
module abu_sel (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  abu_pkg::comb_t  in_data,
  output logic            valid,
  output logic [31:0]     data,
  input  logic            ready_out
);

  logic [31:0] data_next;
  logic [31:0] ext;

  assign in_ready = !valid || ready_out;
  assign ext      = (in_data.ext_f & in_data.ext_m) | (in_data.sext ? ~in_data.ext_m : '0);

  always_comb begin
    case (in_data.action)
      abu_pkg::ACT_CLZ:   data_next = {26'd0, in_data.clz};
      abu_pkg::ACT_BFI,
      abu_pkg::ACT_BFC:   data_next = in_data.bf;
      abu_pkg::ACT_SBFX,
      abu_pkg::ACT_UBFX:  data_next = ext;
      abu_pkg::ACT_REV,
      abu_pkg::ACT_REV16,
      abu_pkg::ACT_RBIT,
      abu_pkg::ACT_REVSH: data_next = in_data.perm;
      default:            data_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

FILE: design/arm32_bit_byte_unit.sv
// Bit and byte manipulation unit: clz, bitfield insert/clear/extract and
// the rev/rev16/rbit/revsh permutations on 32-bit words.
// Input channel: in_valid/in_stall with action, operand_a, operand_b, lsb,
//   msb and width_minus_one; a transaction completes when in_valid is high
//   and in_stall is low.
// Output channel: out_valid/out_stall with result, one per input transaction,
//   in order.
// Three register stages (prep, combine, select) lie between an input
//   transaction and out_valid. Throughput is one transaction per cycle
//   while out_stall is low.
// Each stage holds its item while the stage after it is full and stalled;
//   in_stall rises only when every stage is occupied and out_stall is high.
//   No transaction is lost or repeated across a stall.
// Synchronous reset (rst) empties the pipeline; no item is in flight after it.
// Depends on abu_pkg, abu_prep, abu_comb and abu_sel.
module arm32_bit_byte_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [4:0]  lsb,
  input  logic [4:0]  msb,
  input  logic [4:0]  width_minus_one,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result
);

  logic           s1_ready;
  logic           s1_valid;
  abu_pkg::prep_t s1_data;
  logic           s2_ready;
  logic           s2_valid;
  abu_pkg::comb_t s2_data;
  logic           s3_ready;

  assign in_stall = !s1_ready;

  abu_prep u_prep (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (s1_ready),
    .action          (action),
    .operand_a       (operand_a),
    .operand_b       (operand_b),
    .lsb             (lsb),
    .msb             (msb),
    .width_minus_one (width_minus_one),
    .valid           (s1_valid),
    .data            (s1_data),
    .ready_out       (s2_ready)
  );

  abu_comb u_comb (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_data   (s1_data),
    .valid     (s2_valid),
    .data      (s2_data),
    .ready_out (s3_ready)
  );

  abu_sel u_sel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s3_ready),
    .in_data   (s2_data),
    .valid     (out_valid),
    .data      (result),
    .ready_out (!out_stall)
  );

endmodule
